// File: sv/shrr_pkg.sv
`default_nettype none

package shrr_pkg;

    localparam int MAX_POINTS = 64;
    localparam int SAMPLE_W   = 16;
    localparam int VAL_W      = SAMPLE_W + 1;
    localparam int WORD_W     = 23;
    localparam int ADDR_W     = 6;
    localparam int CNT_W      = 7;
    localparam int LOG_W      = 3;
    localparam int COEF_W     = 19;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGN_MASK = 1'b1;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [ADDR_W-1:0]       addr;
        logic                    store;
        logic                    last;
        logic [LOG_W-1:0]        size_log2;
        logic [CNT_W-1:0]        fill_end;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// File: sv/shrr_front.sv
`default_nettype none

module shrr_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [shrr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [shrr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [shrr_pkg::SAMPLE_W-1:0] s_sample,
    input  wire logic                              s_row_end,
    input  wire shrr_pkg::q_status_t               q_status,
    output logic                                   push,
    output shrr_pkg::q_entry_t                     push_entry
);
    import shrr_pkg::*;

    logic [LOG_W-1:0]      size_log2_reg;
    logic [CFG_DATA_W-1:0] sign_mask_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;

    logic [LOG_W-1:0]        eff_log2;
    logic [CNT_W-1:0]        n_points;
    logic                    store;
    logic signed [VAL_W-1:0] s_ext;
    logic [CNT_W-1:0]        fill_end;

    always_comb begin
        case (size_log2_reg)
            3'd0:    eff_log2 = 3'd1;
            3'd7:    eff_log2 = 3'd6;
            default: eff_log2 = size_log2_reg;
        endcase
    end

    assign n_points = CNT_W'(1) << eff_log2;
    assign store    = (fill_reg < n_points);
    assign s_ext    = VAL_W'(s_sample);
    assign fill_end = fill_reg + CNT_W'(store);

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_entry.value     = sign_mask_reg[fill_reg[ADDR_W-1:0]] ? -s_ext : s_ext;
        push_entry.addr      = fill_reg[ADDR_W-1:0];
        push_entry.store     = store;
        push_entry.last      = s_row_end;
        push_entry.size_log2 = eff_log2;
        push_entry.fill_end  = fill_end;
    end

    always_comb begin
        fill_next = fill_reg;
        if (push) begin
            fill_next = s_row_end ? '0 : fill_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg <= 3'd6;
            sign_mask_reg <= '0;
            fill_reg      <= '0;
        end else begin
            fill_reg <= fill_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SIZE_LOG2: size_log2_reg <= cfg_data[LOG_W-1:0];
                    REG_SIGN_MASK: sign_mask_reg <= cfg_data;
                    default:       sign_mask_reg <= sign_mask_reg;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/shrr_queue.sv
`default_nettype none

module shrr_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire shrr_pkg::q_entry_t  push_entry,
    input  wire logic                pop,
    output shrr_pkg::q_entry_t       head,
    output shrr_pkg::q_status_t      status
);
    import shrr_pkg::*;

    q_entry_t            slots [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slots[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: sv/shrr_back.sv
`default_nettype none

module shrr_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire shrr_pkg::q_entry_t                head,
    input  wire shrr_pkg::q_status_t               q_status,
    output logic                                   pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [shrr_pkg::COEF_W-1:0]     m_coefficient,
    output logic [shrr_pkg::ADDR_W-1:0]            m_position,
    output logic                                   m_final_res
);
    import shrr_pkg::*;

    localparam int PROD_W = WORD_W + 18;
    localparam logic signed [17:0] SCALE_ODD  = 18'sd46341;
    localparam logic signed [17:0] SCALE_EVEN = 18'sd65536;
    localparam logic signed [PROD_W-1:0] PROD_ONE = PROD_W'(1);
    localparam logic signed [PROD_W-1:0] COEF_HI  = PROD_W'(262143);
    localparam logic signed [PROD_W-1:0] COEF_LO  = -PROD_W'(262144);

    typedef enum logic [7:0] {
        ST_LOAD    = 8'b0000_0001,
        ST_ZERO    = 8'b0000_0010,
        ST_BF_RD   = 8'b0000_0100,
        ST_BF_WA   = 8'b0000_1000,
        ST_BF_WB   = 8'b0001_0000,
        ST_EM_RD   = 8'b0010_0000,
        ST_EM_CALC = 8'b0100_0000,
        ST_EM_PUT  = 8'b1000_0000
    } state_t;

    logic signed [WORD_W-1:0] mem [MAX_POINTS];

    state_t                   state_reg, state_next;
    logic [2:0]               stage_reg, stage_next;
    logic [ADDR_W-2:0]        bf_reg, bf_next;
    logic [LOG_W-1:0]         l_reg, l_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic [ADDR_W-1:0]        addr_a_reg, addr_a_next;
    logic [ADDR_W-1:0]        addr_b_reg, addr_b_next;
    logic signed [WORD_W-1:0] rda_reg, rdb_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [COEF_W-1:0] coef_reg, coef_next;
    logic [ADDR_W-1:0]        pos_reg, pos_next;
    logic                     final_reg, final_next;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [WORD_W-1:0] wr_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr_a, rd_addr_b;

    logic [CNT_W-1:0]         n_points;
    logic [CNT_W-1:0]         half_points;
    logic                     bf_last, stage_last, em_last;
    logic [ADDR_W-2:0]        bf_sel;
    logic [ADDR_W-1:0]        span, span_mask, k_ext, bf_a, bf_b;
    logic signed [PROD_W-1:0] rda_ext, scale_ext;
    logic [1:0]               half_log;
    logic signed [PROD_W-1:0] rounded, shifted;
    logic signed [COEF_W-1:0] coef_sat;
    logic                     out_free;

    assign n_points    = CNT_W'(1) << l_reg;
    assign half_points = CNT_W'(1) << (l_reg - 3'd1);
    assign bf_last     = ({2'b00, bf_reg} == half_points - CNT_W'(1));
    assign stage_last  = (stage_reg == l_reg - 3'd1);
    assign em_last     = (ptr_reg == n_points - CNT_W'(1));

    assign bf_sel    = (state_reg == ST_BF_WB) ? bf_reg + 1'b1 : bf_reg;
    assign span      = ADDR_W'(1) << stage_reg;
    assign span_mask = span - ADDR_W'(1);
    assign k_ext     = {1'b0, bf_sel};
    assign bf_a      = ((k_ext & ~span_mask) << 1) | (k_ext & span_mask);
    assign bf_b      = bf_a | span;

    assign rda_ext   = PROD_W'(rda_reg);
    assign scale_ext = l_reg[0] ? PROD_W'(SCALE_ODD) : PROD_W'(SCALE_EVEN);
    assign half_log  = l_reg[2:1];
    assign rounded   = prod_reg + (PROD_ONE <<< (5'd15 + 5'(half_log)));
    assign shifted   = rounded >>> (5'd16 + 5'(half_log));

    always_comb begin
        if (shifted > COEF_HI) begin
            coef_sat = COEF_HI[COEF_W-1:0];
        end else if (shifted < COEF_LO) begin
            coef_sat = COEF_LO[COEF_W-1:0];
        end else begin
            coef_sat = shifted[COEF_W-1:0];
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        stage_next   = stage_reg;
        bf_next      = bf_reg;
        l_next       = l_reg;
        ptr_next     = ptr_reg;
        addr_a_next  = addr_a_reg;
        addr_b_next  = addr_b_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg && !m_ready;
        coef_next    = coef_reg;
        pos_next     = pos_reg;
        final_next   = final_reg;
        pop          = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = addr_a_reg;
        wr_data      = rda_reg + rdb_reg;
        rd_en        = 1'b0;
        rd_addr_a    = bf_a;
        rd_addr_b    = bf_b;

        case (state_reg)
            ST_LOAD: begin
                if (!q_status.empty) begin
                    pop     = 1'b1;
                    wr_en   = head.store;
                    wr_addr = head.addr;
                    wr_data = WORD_W'(head.value);
                    if (head.last) begin
                        l_next     = head.size_log2;
                        ptr_next   = head.fill_end;
                        state_next = ST_ZERO;
                    end
                end
            end
            ST_ZERO: begin
                if (ptr_reg < n_points) begin
                    wr_en    = 1'b1;
                    wr_addr  = ptr_reg[ADDR_W-1:0];
                    wr_data  = '0;
                    ptr_next = ptr_reg + 1'b1;
                end else begin
                    stage_next = '0;
                    bf_next    = '0;
                    state_next = ST_BF_RD;
                end
            end
            ST_BF_RD: begin
                rd_en       = 1'b1;
                addr_a_next = bf_a;
                addr_b_next = bf_b;
                state_next  = ST_BF_WA;
            end
            ST_BF_WA: begin
                wr_en      = 1'b1;
                wr_addr    = addr_a_reg;
                wr_data    = rda_reg + rdb_reg;
                state_next = ST_BF_WB;
            end
            ST_BF_WB: begin
                wr_en   = 1'b1;
                wr_addr = addr_b_reg;
                wr_data = rda_reg - rdb_reg;
                if (!bf_last) begin
                    rd_en       = 1'b1;
                    addr_a_next = bf_a;
                    addr_b_next = bf_b;
                    bf_next     = bf_reg + 1'b1;
                    state_next  = ST_BF_WA;
                end else if (!stage_last) begin
                    stage_next = stage_reg + 1'b1;
                    bf_next    = '0;
                    state_next = ST_BF_RD;
                end else begin
                    ptr_next   = '0;
                    state_next = ST_EM_RD;
                end
            end
            ST_EM_RD: begin
                rd_en      = 1'b1;
                rd_addr_a  = ptr_reg[ADDR_W-1:0];
                state_next = ST_EM_CALC;
            end
            ST_EM_CALC: begin
                prod_next  = rda_ext * scale_ext;
                state_next = ST_EM_PUT;
            end
            ST_EM_PUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    coef_next    = coef_sat;
                    pos_next     = ptr_reg[ADDR_W-1:0];
                    final_next   = em_last;
                    if (em_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr_a  = ADDR_W'(ptr_reg + 1'b1);
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = ST_EM_CALC;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg  <= stage_next;
        bf_reg     <= bf_next;
        l_reg      <= l_next;
        ptr_reg    <= ptr_next;
        addr_a_reg <= addr_a_next;
        addr_b_reg <= addr_b_next;
        prod_reg   <= prod_next;
        coef_reg   <= coef_next;
        pos_reg    <= pos_next;
        final_reg  <= final_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rda_reg <= mem[rd_addr_a];
            rdb_reg <= mem[rd_addr_b];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_coefficient = coef_reg;
    assign m_position    = pos_reg;
    assign m_final_res   = final_reg;

endmodule

`default_nettype wire

// File: sv/signed_hadamard_row_rotation_top.sv
`default_nettype none
// channel   handshake           payload
// -------   -----------------   ----------------------------------------------
// config    cfg_wr_en           cfg_index[0], cfg_data[63:0]
// input     s_valid / s_ready   s_sample[15:0] signed, s_row_end
// result    m_valid / m_ready   m_coefficient[18:0] signed, m_position[5:0],
//                               m_final_res
//
// A row of k words into an N = 2^L point transform passes through the load,
// zero fill of the remaining N - k words, L butterfly stages and emission; the
// single write port of the work buffer makes each butterfly write its two
// results in separate states, ST_BF_WA then ST_BF_WB.
// Reset clears the fill count, the queue and the sequencer; size_log2 becomes 6,
// sign_mask 0. The work buffer is not cleared.
// A 4-word queue lets input words arrive during a transform; s_ready drops only
// when it is full. m_ready low holds the result register and stalls emission.

module signed_hadamard_row_rotation_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [shrr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [shrr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [shrr_pkg::SAMPLE_W-1:0] s_sample,
    input  wire logic                              s_row_end,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [shrr_pkg::COEF_W-1:0]     m_coefficient,
    output logic [shrr_pkg::ADDR_W-1:0]            m_position,
    output logic                                   m_final_res
);
    import shrr_pkg::*;

    q_status_t q_status;
    q_entry_t  push_entry;
    q_entry_t  head;
    logic      push;
    logic      pop;

    shrr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_row_end  (s_row_end),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    shrr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    shrr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coefficient (m_coefficient),
        .m_position    (m_position),
        .m_final_res   (m_final_res)
    );

    a_queue_flags : assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    a_position_step : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_final_res) |=>
            (!m_valid || m_position == ADDR_W'($past(m_position) + 1'b1)))
        else $error("coefficient positions out of order");

    a_row_start : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_final_res) |=> (!m_valid || m_position == '0))
        else $error("row does not restart at position zero");

    a_reset_idle : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

`default_nettype wire
